FILE: sv/sgr_pkg.sv
// Package for the scaled glyph row renderer: font geometry, field widths,
// beat layouts and the structs passed between the renderer's modules.
// No dependencies.
package sgr_pkg;

	// Font geometry.
	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 16;
	localparam int GLYPH_COUNT  = 95;
	localparam int MAX_ZOOM     = 8;
	localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;

	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int ROW_W   = $clog2(GLYPH_HEIGHT);
	localparam int COL_W   = $clog2(GLYPH_WIDTH);
	localparam int GLYPH_W = $clog2(GLYPH_COUNT);

	// Character codes.
	localparam logic [7:0] FIRST_CODE    = 8'd32;  // space
	localparam logic [7:0] LAST_CODE     = 8'd126; // tilde
	localparam logic [7:0] FALLBACK_CODE = 8'd63;  // question mark

	// Function selector carried in the input tuser.
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_RENDER = 1'b1;

	// Result status carried in the output tuser.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	// Field widths.
	localparam int FONT_ADDR_W = 11;
	localparam int FONT_BYTE_W = 8;
	localparam int CODE_W      = 8;
	localparam int ORIGIN_W    = 16;
	localparam int SROW_W      = 7;
	localparam int ZOOM_W      = 4;
	localparam int COLOR_W     = 24;
	localparam int PIX_W       = 17;

	// Beat widths, padded to whole bytes.
	localparam int S_DATA_W = 120;
	localparam int M_DATA_W = 64;

	// One input beat, unpacked.
	typedef struct packed {
		logic                   func;
		logic [FONT_ADDR_W-1:0] font_addr;
		logic [FONT_BYTE_W-1:0] font_byte;
		logic [CODE_W-1:0]      char_code;
		logic [ORIGIN_W-1:0]    origin_x;
		logic [ORIGIN_W-1:0]    origin_y;
		logic [SROW_W-1:0]      scaled_row;
		logic [ZOOM_W-1:0]      zoom;
		logic [COLOR_W-1:0]     fg_color;
		logic [COLOR_W-1:0]     bg_color;
		logic                   shadow_on;
	} item_t;

	// Font store access, one port.
	typedef struct packed {
		logic                   wr_en;
		logic                   rd_en;
		logic [ADDR_W-1:0]      addr;
		logic [FONT_BYTE_W-1:0] wdata;
	} mem_req_t;

	// Row divider request and response.
	typedef struct packed {
		logic              start;
		logic [SROW_W-1:0] dividend;
		logic [ZOOM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SROW_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: sv/sgr_font_mem.sv
// Font store of the glyph row renderer: single-port synchronous RAM,
// one byte per glyph row, read data registered. Depends on sgr_pkg.
module sgr_font_mem (
	input  logic                           clk,
	input  sgr_pkg::mem_req_t              req,
	output logic [sgr_pkg::FONT_BYTE_W-1:0] rd_data
);
	import sgr_pkg::*;

	logic [FONT_BYTE_W-1:0] mem [STORE_DEPTH];

	// Write and read share the port; the sequencer never issues both at once.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.addr];
		end
	end

endmodule

FILE: sv/sgr_row_div.sv
// Restoring divider for the glyph row index: scaled_row / zoom, one
// quotient bit per cycle. Depends on sgr_pkg.
module sgr_row_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sgr_pkg::div_req_t req,
	output sgr_pkg::div_rsp_t rsp
);
	import sgr_pkg::*;

	localparam int CNT_W = $clog2(SROW_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SROW_W-1:0]    dvd_q;
	logic [ZOOM_W-1:0]    dvs_q;
	logic [ZOOM_W-1:0]    rem_q;
	logic [ZOOM_W:0]      trial;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder and try the divisor.
	assign trial = {rem_q, dvd_q[SROW_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(SROW_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Datapath; quotient bits enter at the bottom of the dividend register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SROW_W-2:0], fits};
			rem_q <= fits ? ZOOM_W'(trial - {1'b0, dvs_q}) : trial[ZOOM_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

endmodule

FILE: sv/sgr_pixel_seq.sv
// Sequencer of the glyph row renderer: takes input beats, writes the font
// store, reads one glyph row and emits its pixels through an output register.
// Depends on sgr_pkg.
module sgr_pixel_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sgr_pkg::item_t                  item,
	input  logic                            in_valid,
	output logic                            in_ready,
	output sgr_pkg::mem_req_t               mem_req,
	input  logic [sgr_pkg::FONT_BYTE_W-1:0] rd_data,
	output sgr_pkg::div_req_t               div_req,
	input  sgr_pkg::div_rsp_t               div_rsp,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sgr_pkg::M_DATA_W-1:0]    out_data,
	output logic                            out_status,
	output logic                            out_last
);
	import sgr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]           state_q;
	logic                 acc;
	logic                 slot_free;
	logic                 req_ok;
	logic                 reject;
	logic                 load_hit;
	logic [7:0]           code_fix;
	logic [GLYPH_W-1:0]   glyph_idx;

	logic [GLYPH_W-1:0]   glyph_q;
	logic [ZOOM_W-1:0]    zoom_q;
	logic [PIX_W-1:0]     x_q;
	logic [PIX_W-1:0]     y_q;
	logic [COLOR_W-1:0]   fg_q;
	logic [COLOR_W-1:0]   bg_q;
	logic                 shadow_q;
	logic [ADDR_W-1:0]    rd_addr_q;
	logic [COL_W-1:0]     col_q;
	logic [ZOOM_W-1:0]    rep_q;

	logic [COL_W-1:0]     bit_idx;
	logic [COL_W-1:0]     left_idx;
	logic                 cur_bit;
	logic                 left_bit;
	logic                 rep_end;
	logic                 row_end;
	logic                 emit;
	logic [COLOR_W-1:0]   pix_color;

	logic                 m_valid_q;
	logic [M_DATA_W-1:0]  m_data_q;
	logic                 m_status_q;
	logic                 m_last_q;

	// Handshake: the output register must be free or draining.
	assign slot_free = !m_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign acc       = in_valid && in_ready;

	// Request checks and glyph selection.
	assign req_ok = (item.zoom != '0) && (32'(item.zoom) <= MAX_ZOOM)
		&& (32'(item.scaled_row) < GLYPH_HEIGHT * 32'(item.zoom));
	assign reject = acc && (item.func == FUNC_RENDER) && !req_ok;
	assign load_hit = 32'(item.font_addr) < STORE_DEPTH;
	assign code_fix = (item.char_code < FIRST_CODE || item.char_code > LAST_CODE)
		? FALLBACK_CODE : item.char_code;
	assign glyph_idx = GLYPH_W'(code_fix - FIRST_CODE);

	// Font store port: loads in idle, the row read after the division.
	always_comb begin
		mem_req.wr_en = acc && (item.func == FUNC_LOAD) && load_hit;
		mem_req.rd_en = (state_q == ST_READ);
		mem_req.addr  = mem_req.rd_en ? rd_addr_q : ADDR_W'(item.font_addr);
		mem_req.wdata = item.font_byte;
	end

	assign div_req.start    = acc && (item.func == FUNC_RENDER) && req_ok;
	assign div_req.dividend = item.scaled_row;
	assign div_req.divisor  = item.zoom;

	// Pixel of the current column; the left neighbor of column zero is clear.
	assign bit_idx   = COL_W'(GLYPH_WIDTH - 1) - col_q;
	assign left_idx  = bit_idx + COL_W'(1);
	assign cur_bit   = rd_data[bit_idx];
	assign left_bit  = (col_q != '0) && rd_data[left_idx];
	assign pix_color = (shadow_q && !cur_bit && left_bit) ? '0
		: (cur_bit ? fg_q : bg_q);
	assign rep_end   = rep_q == ZOOM_W'(zoom_q - ZOOM_W'(1));
	assign row_end   = rep_end && (col_q == COL_W'(GLYPH_WIDTH - 1));
	assign emit      = (state_q == ST_EMIT) && slot_free;

	// State and output valid; a beat stays valid until taken, and a new pixel
	// or a rejected request fills the register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= (m_valid_q && !out_ready) || reject || emit;
			case (state_q)
				ST_IDLE: begin
					if (div_req.start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit && row_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request registers and column counters.
	always_ff @(posedge clk) begin
		if (acc) begin
			glyph_q  <= glyph_idx;
			zoom_q   <= item.zoom;
			x_q      <= PIX_W'(item.origin_x);
			y_q      <= PIX_W'(item.origin_y) + PIX_W'(item.scaled_row);
			fg_q     <= item.fg_color;
			bg_q     <= item.bg_color;
			shadow_q <= item.shadow_on;
			col_q    <= '0;
			rep_q    <= '0;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			rd_addr_q <= ADDR_W'(glyph_q) * ADDR_W'(GLYPH_HEIGHT)
				+ ADDR_W'(div_rsp.quot[ROW_W-1:0]);
		end
		if (emit) begin
			x_q <= x_q + PIX_W'(1);
			if (rep_end) begin
				rep_q <= '0;
				col_q <= col_q + COL_W'(1);
			end else begin
				rep_q <= rep_q + ZOOM_W'(1);
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (reject) begin
			m_data_q   <= '0;
			m_status_q <= STATUS_INVALID;
			m_last_q   <= 1'b1;
		end else if (emit) begin
			m_data_q   <= M_DATA_W'({pix_color, y_q, x_q});
			m_status_q <= STATUS_OK;
			m_last_q   <= row_end;
		end
	end

	assign out_valid  = m_valid_q;
	assign out_data   = m_data_q;
	assign out_status = m_status_q;
	assign out_last   = m_last_q;

endmodule

FILE: sv/scaled_glyph_row_renderer.sv
// Top level of the scaled glyph row renderer: beat unpacking and the
// font store, divider and pixel sequencer. Depends on sgr_pkg and submodules.
//
// A load beat (tuser 0) writes one byte of the 1520-byte font store. A
// render beat (tuser 1) passes through the bit-serial row divider (seven
// quotient bits and the handoff of the result) and the font store read,
// then sends 8*zoom pixel beats, one per cycle while the output is taken;
// the next beat is taken only after the last pixel. A request with a bad
// zoom or row gives one beat with tuser 1. The font store has no reset;
// render only glyphs whose rows were loaded.
module scaled_glyph_row_renderer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// font_addr[10:0], font_byte[18:11], char_code[26:19], origin_x[42:27],
	// origin_y[58:43], scaled_row[65:59], zoom[69:66], fg_color[93:70],
	// bg_color[117:94], shadow_on[118], zero[119]
	input  logic [sgr_pkg::S_DATA_W-1:0] s_axis_tdata,
	// func[0]
	input  logic                         s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// pixel_x[16:0], pixel_y[33:17], pixel_color[57:34], zero[63:58]
	output logic [sgr_pkg::M_DATA_W-1:0] m_axis_tdata,
	// status[0]
	output logic                         m_axis_tuser,
	// last
	output logic                         m_axis_tlast
);
	import sgr_pkg::*;

	item_t                  item;
	mem_req_t               mem_req;
	logic [FONT_BYTE_W-1:0] rd_data;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	// Input beat fields.
	always_comb begin
		item.func       = s_axis_tuser;
		item.font_addr  = s_axis_tdata[10:0];
		item.font_byte  = s_axis_tdata[18:11];
		item.char_code  = s_axis_tdata[26:19];
		item.origin_x   = s_axis_tdata[42:27];
		item.origin_y   = s_axis_tdata[58:43];
		item.scaled_row = s_axis_tdata[65:59];
		item.zoom       = s_axis_tdata[69:66];
		item.fg_color   = s_axis_tdata[93:70];
		item.bg_color   = s_axis_tdata[117:94];
		item.shadow_on  = s_axis_tdata[118];
	end

	sgr_font_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	sgr_row_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sgr_pixel_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.mem_req    (mem_req),
		.rd_data    (rd_data),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_status (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

endmodule

FILE: sv/sgr_checker.sv
// Port-level checks for the scaled glyph row renderer, bound to the top
// level. Depends on sgr_pkg and scaled_glyph_row_renderer.
module sgr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [sgr_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic                         m_axis_tuser,
	input logic                         m_axis_tlast
);
	import sgr_pkg::*;

	// An invalid-request beat carries no pixel and closes its row.
	a_invalid_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STATUS_INVALID
		|-> m_axis_tlast && m_axis_tdata == '0)
		else $error("invalid beat with pixel data or without last");

	// No new beat is taken while a row is still being sent.
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken in the middle of a row");

	// Input is taken only when the output register can take a new beat.
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && m_axis_tvalid |-> m_axis_tready)
		else $error("input ready while output is stalled");

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("stalled output beat changed");

endmodule

bind scaled_glyph_row_renderer sgr_checker u_sgr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: tb/sv/tb_scaled_glyph_row_renderer.sv
`timescale 1ns / 1ps
// Self-checking testbench for scaled_glyph_row_renderer: a scoreboard class
// predicts the pixel beats of every glyph row render and checks them in order.
// Depends on sgr_pkg and the renderer RTL.
module tb_scaled_glyph_row_renderer;
	import sgr_pkg::*;

	// One result beat, split into its fields.
	typedef struct packed {
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [COLOR_W-1:0] color;
		logic               status;
		logic               last;
	} pixel_beat_t;

	class pixel_scoreboard;
		logic [FONT_BYTE_W-1:0] font_rows [STORE_DEPTH];
		bit                     loaded [STORE_DEPTH];
		pixel_beat_t            expected_pixels [$];
		int                     failures;
		int                     pixels_checked;
		int                     rejects_checked;
		int                     loads_seen;
		int                     renders_seen;

		// Font store index that a render reads, or -1 when its zoom or row is bad.
		function int row_index(item_t it);
			logic [CODE_W-1:0] code;
			if (it.zoom == 0 || it.zoom > MAX_ZOOM || it.scaled_row >= GLYPH_HEIGHT * it.zoom)
				return -1;
			code = it.char_code;
			if (code < FIRST_CODE || code > LAST_CODE)
				code = FALLBACK_CODE;
			return (int'(code) - int'(FIRST_CODE)) * GLYPH_HEIGHT
				+ int'(it.scaled_row) / int'(it.zoom);
		endfunction

		// Applies an accepted load, or queues the pixels an accepted render must produce.
		function void note_accepted(item_t it);
			int                     idx;
			int                     total;
			int                     base;
			logic [FONT_BYTE_W-1:0] rowbits;
			logic                   lit;
			logic                   left_lit;
			pixel_beat_t            px;
			if (it.func == FUNC_LOAD) begin
				loads_seen++;
				if (it.font_addr < STORE_DEPTH) begin
					font_rows[it.font_addr] = it.font_byte;
					loaded[it.font_addr] = 1'b1;
				end
				return;
			end
			renders_seen++;
			idx = row_index(it);
			if (idx < 0) begin
				px = '0;
				px.status = STATUS_INVALID;
				px.last = 1'b1;
				expected_pixels.push_back(px);
				return;
			end
			rowbits = font_rows[idx];
			total = GLYPH_WIDTH * it.zoom;
			for (int col = 0; col < total; col++) begin
				base = col / it.zoom;
				lit = rowbits[GLYPH_WIDTH - 1 - base];
				// The leftmost column has no neighbor, so it never takes a shadow.
				left_lit = (base > 0) ? rowbits[GLYPH_WIDTH - base] : 1'b0;
				px.x = PIX_W'(int'(it.origin_x) + col);
				px.y = PIX_W'(int'(it.origin_y) + int'(it.scaled_row));
				if (it.shadow_on && !lit && left_lit)
					px.color = '0;
				else
					px.color = lit ? it.fg_color : it.bg_color;
				px.status = STATUS_OK;
				px.last = (col == total - 1);
				expected_pixels.push_back(px);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		// Checks one accepted result beat against the oldest expected pixel.
		function void check_pixel(pixel_beat_t got);
			pixel_beat_t want;
			if (expected_pixels.size() == 0) begin
				$error("Unexpected result beat: x %0d y %0d color 0x%06h status %0d last %0d",
					got.x, got.y, got.color, got.status, got.last);
				failures++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("pixel_x", 32'(want.x), 32'(got.x));
			compare_field("pixel_y", 32'(want.y), 32'(got.y));
			compare_field("pixel_color", 32'(want.color), 32'(got.color));
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("last", 32'(want.last), 32'(got.last));
			if (want.status == STATUS_OK)
				pixels_checked++;
			else
				rejects_checked++;
		endfunction
	endclass

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 10;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 10 + GLYPH_WIDTH * MAX_ZOOM + 16;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int PHASE_ITEMS  = 52;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic                s_axis_tuser = FUNC_LOAD;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic                m_axis_tuser;
	logic                m_axis_tlast;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int beats_sent = 0;

	pixel_scoreboard sb = new();
	pixel_beat_t     seen;

	scaled_glyph_row_renderer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Output ready: a long hold-off on request, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every result beat taken at this edge goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.x = m_axis_tdata[16:0];
			seen.y = m_axis_tdata[33:17];
			seen.color = m_axis_tdata[57:34];
			seen.status = m_axis_tuser;
			seen.last = m_axis_tlast;
			sb.check_pixel(seen);
		end
	end

	// The run ends here if the block hangs.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Timed out with %0d pixel beats outstanding.", sb.expected_pixels.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic item_t random_beat();
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	// Offers one beat after a random number of idle cycles and waits until it is taken.
	task automatic send_beat(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.func;
		s_axis_tdata <= {1'b0, it.shadow_on, it.bg_color, it.fg_color, it.zoom,
			it.scaled_row, it.origin_y, it.origin_x, it.char_code, it.font_byte,
			it.font_addr};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_accepted(it);
		beats_sent++;
	endtask

	task automatic send_load(input logic [FONT_ADDR_W-1:0] addr,
			input logic [FONT_BYTE_W-1:0] value);
		item_t it;
		it = random_beat();
		it.func = FUNC_LOAD;
		it.font_addr = addr;
		it.font_byte = value;
		send_beat(it);
	endtask

	// Renders one row; a font row that was never loaded gets a random byte first.
	task automatic send_render(input item_t it);
		int idx;
		idx = sb.row_index(it);
		if (idx >= 0 && !sb.loaded[idx])
			send_load(FONT_ADDR_W'(idx), FONT_BYTE_W'($urandom));
		it.func = FUNC_RENDER;
		send_beat(it);
	endtask

	function automatic item_t render_item(input logic [CODE_W-1:0] code, input int srow,
			input int zoom, input logic shadow);
		item_t it;
		it = random_beat();
		it.char_code = code;
		it.scaled_row = SROW_W'(srow);
		it.zoom = ZOOM_W'(zoom);
		it.shadow_on = shadow;
		return it;
	endfunction

	// Mostly valid renders at small zooms, some loads and some bad requests.
	task automatic send_random_item();
		item_t it;
		int    pick;
		int    zoom;
		pick = $urandom_range(99);
		it = random_beat();
		if (pick < 15) begin
			send_load(it.font_addr, it.font_byte);
			return;
		end
		if (pick < 25) begin
			case ($urandom_range(2))
				0: it.zoom = '0;
				1: it.zoom = ZOOM_W'($urandom_range(15, MAX_ZOOM + 1));
				default: begin
					// Row below the bottom of the zoomed glyph.
					it.zoom = ZOOM_W'($urandom_range(MAX_ZOOM - 1, 1));
					it.scaled_row = SROW_W'($urandom_range(127, GLYPH_HEIGHT * it.zoom));
				end
			endcase
		end else begin
			pick = $urandom_range(99);
			if (pick < 60)
				zoom = $urandom_range(2, 1);
			else if (pick < 90)
				zoom = $urandom_range(4, 3);
			else
				zoom = $urandom_range(MAX_ZOOM, 5);
			it.zoom = ZOOM_W'(zoom);
			it.scaled_row = SROW_W'($urandom_range(GLYPH_HEIGHT * zoom - 1));
			if ($urandom_range(99) < 80)
				it.char_code = CODE_W'($urandom_range(LAST_CODE, FIRST_CODE));
		end
		send_render(it);
	endtask

	initial begin
		item_t it;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct <= 32;
		recv_idle_pct <= 73;

		// Loads past the end of the store are dropped, then in-range rows are loaded.
		send_load('1, 8'hFF);
		send_load(FONT_ADDR_W'(STORE_DEPTH), 8'hFF);
		send_load('0, 8'hFF);
		send_load(FONT_ADDR_W'(STORE_DEPTH - 1), 8'h81);
		send_load(FONT_ADDR_W'((FALLBACK_CODE - FIRST_CODE) * GLYPH_HEIGHT), 8'hAA);

		// Field extremes: first and last glyph, smallest and largest zoom and origin.
		it = render_item(FIRST_CODE, 0, 1, 1'b0);
		it.origin_x = '0;
		it.origin_y = '0;
		it.fg_color = '1;
		it.bg_color = '0;
		send_render(it);
		it = render_item(LAST_CODE, 127, MAX_ZOOM, 1'b1);
		it.origin_x = '1;
		it.origin_y = '1;
		it.fg_color = '0;
		it.bg_color = '1;
		send_render(it);

		// Codes outside the printable range fall back to the question mark.
		send_render(render_item(8'd0, 0, 1, 1'b1));
		send_render(render_item(8'd255, 1, 2, 1'b1));
		send_render(render_item(CODE_W'(FIRST_CODE - 1), 0, 1, 1'b0));
		send_render(render_item(CODE_W'(LAST_CODE + 1), 0, 1, 1'b0));

		// Bad zoom and rows just past the zoomed glyph, then the last good row.
		send_render(render_item(FALLBACK_CODE, 0, 0, 1'b0));
		send_render(render_item(FALLBACK_CODE, 0, MAX_ZOOM + 1, 1'b0));
		send_render(render_item(FALLBACK_CODE, 0, 15, 1'b0));
		send_render(render_item(FALLBACK_CODE, GLYPH_HEIGHT, 1, 1'b0));
		send_render(render_item(FALLBACK_CODE, 2 * GLYPH_HEIGHT, 2, 1'b0));
		send_render(render_item("A", 2 * GLYPH_HEIGHT - 1, 2, 1'b1));

		// Clear leftmost column with shadow on stays background.
		send_load(FONT_ADDR_W'((FALLBACK_CODE - FIRST_CODE) * GLYPH_HEIGHT), 8'h7F);
		send_render(render_item(FALLBACK_CODE, 0, 3, 1'b1));
		send_render(render_item(LAST_CODE, 0, 7, 1'b1));

		repeat (PHASE_ITEMS) send_random_item();

		send_idle_pct <= 73;
		recv_idle_pct <= 32;
		repeat (PHASE_ITEMS) send_random_item();

		// No idling, and one long output stall so the block backs up into its input.
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		hold_req <= hold_req + 1;
		repeat (PHASE_ITEMS) send_random_item();
		s_axis_tvalid <= 1'b0;

		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d input beats: %0d font loads and %0d row renders.",
			beats_sent, sb.loads_seen, sb.renders_seen);
		$display("Checked %0d pixel beats and %0d rejected requests over three stall patterns.",
			sb.pixels_checked, sb.rejects_checked);
		if (sb.failures == 0 && sb.expected_pixels.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
